>>> rtl/core/ata_pkg.sv
// Shared widths, register indexes and reset values for the averaged temperature alarm.
package ata_pkg;

  // Field widths.
  localparam int unsigned SampleW  = 10;
  localparam int unsigned RefW     = 13;
  localparam int unsigned TempW    = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;

  // Sensor scaling: 10 mV per degree against a 1023-step converter.
  localparam int unsigned ScaleDiv = 10230;

  // Register reset values.
  localparam logic [RefW-1:0]  RefMvReset     = 13'd5000;
  localparam logic [TempW-1:0] TempLimitReset = 10'd40;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_REF_MV     = 1'b0,
    REG_TEMP_LIMIT = 1'b1
  } cfg_reg_e;

endpackage

>>> rtl/core/averaged_temperature_alarm.sv
// Moving-average temperature alarm: sample window, running sum, scaling and threshold.
// Each input transfer passes the sum, product, estimate and corrected-result registers.
// Throughput: one sample per cycle; each pipeline stage holds only when the next is full.
// The running sum is the only loop and closes in one add/subtract per cycle.
// Reset: the sample window fills with RESET_SAMPLE, the sum with SAMPLE_COUNT times that,
// the registers take their default values, and the pipeline comes up empty.
module averaged_temperature_alarm #(
  parameter int unsigned SAMPLE_COUNT = 16,
  parameter int unsigned RESET_SAMPLE = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ata_pkg::SampleW-1:0]     adc_sample_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ata_pkg::TempW-1:0]       temperature_o,
  output logic                            over_limit_o,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ata_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ata_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int unsigned SampleW = ata_pkg::SampleW;
  localparam int unsigned TempW   = ata_pkg::TempW;
  localparam int unsigned RefW    = ata_pkg::RefW;
  localparam int unsigned SumW    = $clog2(SAMPLE_COUNT * 1023 + 1);
  localparam int unsigned ProdW   = SumW + RefW;
  localparam int unsigned Div     = ata_pkg::ScaleDiv * SAMPLE_COUNT;
  localparam int unsigned DivW    = $clog2(Div + 1);
  // Reciprocal of the divisor scaled by 2^ProdW; the quotient estimate is at most one low.
  localparam logic [63:0] Recip   = (64'd1 << ProdW) / Div;
  localparam int unsigned RecipW  = $clog2(Recip + 1);

  localparam logic [RecipW-1:0]  RecipC = RecipW'(Recip);
  localparam logic [DivW-1:0]    DivC   = DivW'(Div);

  // Configuration registers.
  logic [RefW-1:0]  ref_mv_q;
  logic [TempW-1:0] temp_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mv_q     <= ata_pkg::RefMvReset;
      temp_limit_q <= ata_pkg::TempLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ata_pkg::REG_REF_MV:     ref_mv_q     <= cfg_wdata_i[RefW-1:0];
        ata_pkg::REG_TEMP_LIMIT: temp_limit_q <= cfg_wdata_i[TempW-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes: a stage may load when it is empty or its content moves on.
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic out_free, c_free, b_free, a_free;
  logic in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign c_free     = !c_valid_q || out_free;
  assign b_free     = !b_valid_q || c_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_ready_o = a_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free)   a_valid_q   <= in_xfer;
      if (b_free)   b_valid_q   <= a_valid_q;
      if (c_free)   c_valid_q   <= b_valid_q;
      if (out_free) out_valid_q <= c_valid_q;
    end
  end

  // Sample window as a shift line: the oldest sample sits at the far end.
  logic [SampleW-1:0] window_q [SAMPLE_COUNT];
  logic [SumW-1:0]    sum_q;
  logic [SumW-1:0]    sum_d;

  assign sum_d = (sum_q - SumW'(window_q[SAMPLE_COUNT-1])) + SumW'(adc_sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SAMPLE_COUNT; i++) begin
        window_q[i] <= SampleW'(RESET_SAMPLE);
      end
      sum_q <= SumW'(SAMPLE_COUNT * RESET_SAMPLE);
    end else if (in_xfer) begin
      window_q[0] <= adc_sample_i;
      for (int unsigned i = 1; i < SAMPLE_COUNT; i++) begin
        window_q[i] <= window_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  // Stage B: sum times reference. Stage C: quotient estimate by reciprocal multiply.
  logic [ProdW-1:0]        prod_q, prod_c_q;
  logic [ProdW+RecipW-1:0] q_full;
  logic [TempW-1:0]        q_est_q;

  assign q_full = ProdW'(prod_q) * RecipC;

  always_ff @(posedge clk_i) begin
    if (b_free && a_valid_q) begin
      prod_q <= ProdW'(sum_q) * ProdW'(ref_mv_q);
    end
    if (c_free && b_valid_q) begin
      prod_c_q <= prod_q;
      q_est_q  <= TempW'(q_full >> ProdW);
    end
  end

  // Stage D: remainder check corrects the estimate; threshold compares run alongside.
  logic [ProdW-1:0] q_times_div;
  logic [ProdW-1:0] rem;
  logic             bump;
  logic             ge_est, ge_est_plus;
  logic [TempW-1:0] temp_q;
  logic             over_q;

  assign q_times_div = ProdW'(q_est_q) * ProdW'(DivC);
  assign rem         = prod_c_q - q_times_div;
  assign bump        = rem >= ProdW'(Div);
  assign ge_est      = q_est_q >= temp_limit_q;
  assign ge_est_plus = ({1'b0, q_est_q} + (TempW+1)'(1)) >= {1'b0, temp_limit_q};

  always_ff @(posedge clk_i) begin
    if (out_free && c_valid_q) begin
      temp_q <= bump ? q_est_q + TempW'(1) : q_est_q;
      over_q <= bump ? ge_est_plus : ge_est;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = temp_q;
  assign over_limit_o  = over_q;

  // The input side only blocks when every stage is full behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i && a_valid_q && b_valid_q && c_valid_q))
    else $error("input stalled while the pipeline has room");

  // The running sum never exceeds a full window of maximum samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SumW'(SAMPLE_COUNT * 1023))
    else $error("running sum out of range");

  // The running sum moves only on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(sum_q))
    else $error("running sum changed without a transfer");

  // The reciprocal estimate is never more than one below the true quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> (q_times_div <= prod_c_q && rem < ProdW'(2 * Div)))
    else $error("quotient estimate outside correction range");

endmodule

>>> dv/averaged_temperature_alarm_tb.sv
// Self-checking testbench for the averaged temperature alarm, with its own window predictor.
`timescale 1ns / 1ps

module averaged_temperature_alarm_tb;

  localparam int unsigned SAMPLE_COUNT = 16;
  localparam int unsigned RESET_SAMPLE = 40;
  localparam int unsigned LATENCY      = 3;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASES       = 8;

  localparam int unsigned SampleW  = ata_pkg::SampleW;
  localparam int unsigned TempW    = ata_pkg::TempW;
  localparam int unsigned RefW     = ata_pkg::RefW;
  localparam int unsigned CfgIdxW  = ata_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = ata_pkg::CfgDataW;
  localparam int unsigned ScaleDiv = ata_pkg::ScaleDiv;

  typedef struct packed {
    logic [TempW-1:0] temperature;
    logic             over_limit;
  } reading_t;

  typedef enum int unsigned {
    MODE_UNIFORM,
    MODE_RAILS,
    MODE_STEADY,
    MODE_NEAR
  } sample_mode_e;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [SampleW-1:0]  adc_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [TempW-1:0]    temperature_o;
  logic                over_limit_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = ata_pkg::REG_REF_MV;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;

  // Shadow of the sample window and the configuration registers.
  logic [SampleW-1:0]  window [SAMPLE_COUNT];
  int unsigned         window_sum;
  int unsigned         window_pos;
  logic [RefW-1:0]     ref_mv;
  logic [TempW-1:0]    temp_limit;

  reading_t            expected_readings [$];
  int unsigned         mismatches = 0;
  bit                  gaps_on    = 1'b1;

  averaged_temperature_alarm #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .RESET_SAMPLE (RESET_SAMPLE)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_sample_i  (adc_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .temperature_o (temperature_o),
    .over_limit_o  (over_limit_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Replaces the oldest sample in the window and returns the averaged reading.
  function automatic reading_t average_sample(input logic [SampleW-1:0] sample);
    reading_t    r;
    int unsigned scaled;
    window_sum         = window_sum - window[window_pos] + sample;
    window[window_pos] = sample;
    window_pos         = (window_pos + 1) % SAMPLE_COUNT;
    scaled             = window_sum * ref_mv;
    r.temperature      = TempW'(scaled / (ScaleDiv * SAMPLE_COUNT));
    r.over_limit       = (r.temperature >= temp_limit);
    return r;
  endfunction

  // Sends one sample, with an occasional gap in front, and predicts its reading on transfer.
  task automatic send_sample(input logic [SampleW-1:0] sample);
    if (gaps_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(average_sample(sample));
  endtask

  // Writes one register; the caller lowers the valid after its last write.
  task automatic write_register(input ata_pkg::cfg_reg_e idx,
                                input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ata_pkg::REG_REF_MV:     ref_mv     = data[RefW-1:0];
      ata_pkg::REG_TEMP_LIMIT: temp_limit = data[TempW-1:0];
      default: ;
    endcase
  endtask

  // Writes both registers while the block is idle.
  task automatic apply_settings(input logic [CfgDataW-1:0] ref_val,
                                input logic [CfgDataW-1:0] limit_val);
    write_register(ata_pkg::REG_REF_MV, ref_val);
    write_register(ata_pkg::REG_TEMP_LIMIT, limit_val);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops sending and waits until every predicted reading has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random back-pressure and a field-by-field compare on each transfer.
  always @(posedge clk_i) begin
    reading_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("reading %0d/%0b with none expected",
                                  temperature_o, over_limit_o));
      end else begin
        want = expected_readings.pop_front();
        if (temperature_o !== want.temperature)
          report_mismatch($sformatf("temperature %0d, expected %0d",
                                    temperature_o, want.temperature));
        if (over_limit_o !== want.over_limit)
          report_mismatch($sformatf("over_limit %0b, expected %0b (temperature %0d)",
                                    over_limit_o, want.over_limit, want.temperature));
      end
    end
    out_ready_i <= !(gaps_on && $urandom_range(99) < 30);
  end

  // Default registers: the reset sample itself, then both rails of the converter.
  task automatic test_reset_window();
    send_sample(SampleW'(RESET_SAMPLE));
    send_sample(10'd0);
    send_sample(10'd1023);
  endtask

  // Largest reference with a full-scale window reaches the top temperature, equal to the
  // limit; a zero reference and a limit beyond reach keep the flag low; a zero limit sets it.
  task automatic test_scaling_extremes();
    wait_for_results();
    apply_settings(13'h1FFF, 13'd819);
    repeat (SAMPLE_COUNT) send_sample(10'd1023);
    wait_for_results();
    apply_settings(13'd0, 13'h1FFF);
    send_sample(10'd1023);
    send_sample(10'd0);
    wait_for_results();
    apply_settings(13'd1000, 13'd0);
    send_sample(10'd512);
  endtask

  // Several register settings, each followed by bursts of random samples.
  task automatic test_random_settings();
    logic [CfgDataW-1:0] ref_val;
    logic [CfgDataW-1:0] limit_val;
    sample_mode_e        mode;
    int                  level;
    int                  v;
    int unsigned         run;
    int unsigned         sent;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      case ($urandom_range(3))
        0:       ref_val = CfgDataW'($urandom_range(5500, 1000));
        1:       ref_val = ($urandom_range(1)) ? 13'h1FFF : 13'd0;
        2:       ref_val = CfgDataW'($urandom_range(8191));
        default: ref_val = 13'd5000;
      endcase
      case ($urandom_range(3))
        0: limit_val = CfgDataW'($urandom_range(550));
        1: limit_val = CfgDataW'($urandom_range(8191));
        2: begin
          // Near the temperature of a mid-scale window, so the flag toggles.
          v = int'((512 * ref_val) / ScaleDiv) + int'($urandom_range(20)) - 10;
          limit_val = (v < 0) ? '0 : CfgDataW'(v);
        end
        default: limit_val = ($urandom_range(1)) ? 13'd550 : 13'd0;
      endcase
      // The first two phases sit at the ends of the stated ranges.
      if (phase == 0) begin
        ref_val   = 13'd5500;
        limit_val = 13'd550;
      end else if (phase == 1) begin
        ref_val   = 13'd1000;
        limit_val = 13'd0;
      end
      apply_settings(ref_val, limit_val);
      // One phase runs with no gaps on either side.
      gaps_on = (phase != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mode  = sample_mode_e'($urandom_range(3));
        run   = $urandom_range(24, 1);
        level = int'($urandom_range(1023));
        for (int unsigned k = 0; k < run && sent < PHASE_ITEMS; k++) begin
          case (mode)
            MODE_UNIFORM: v = int'($urandom_range(1023));
            MODE_RAILS:   v = ($urandom_range(1)) ? 1023 : 0;
            MODE_STEADY:  v = level;
            default: begin
              v = level + int'($urandom_range(16)) - 8;
              if (v < 0) v = 0;
              if (v > 1023) v = 1023;
            end
          endcase
          send_sample(SampleW'(v));
          sent++;
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence.
  initial begin
    foreach (window[i]) window[i] = SampleW'(RESET_SAMPLE);
    window_sum = SAMPLE_COUNT * RESET_SAMPLE;
    window_pos = 0;
    ref_mv     = ata_pkg::RefMvReset;
    temp_limit = ata_pkg::TempLimitReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_window();
    test_scaling_extremes();
    test_random_settings();
    wait_for_results();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("timeout with %0d readings outstanding", expected_readings.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
